FILE: src/aapr_pkg.sv
// ----------------------------------------------------------------------------
// Axis-angle point rotation package
// Word types of both channels (shared with the checker), the pipeline stage
// records and the fixed-point constants and arctangent table of the core.
// ----------------------------------------------------------------------------
package aapr_pkg;

	localparam int ROOT_STEPS = 32;
	localparam int DIV_STEPS  = 31;

	localparam logic signed [35:0] PI_Q30      = 36'sd3373259426;
	localparam logic signed [35:0] HALF_PI_Q30 = 36'sd1686629713;
	localparam logic signed [35:0] TWO_PI_Q30  = 36'sd6746518852;
	localparam logic signed [33:0] GAIN_Q30    = 34'sd652032874;
	localparam logic signed [32:0] ONE_Q30     = 33'sd1073741824;
	localparam logic signed [65:0] HALF_Q30    = 66'sd536870912;

	typedef struct packed {
		logic signed [31:0] axis_x;
		logic signed [31:0] axis_y;
		logic signed [31:0] axis_z;
		logic signed [23:0] angle;
		logic signed [31:0] point_x;
		logic signed [31:0] point_y;
		logic signed [31:0] point_z;
	} in_word_t;

	typedef struct packed {
		logic signed [31:0] rotated_x;
		logic signed [31:0] rotated_y;
		logic signed [31:0] rotated_z;
		logic               axis_error;
	} out_word_t;

	// Square-root stage record; the sine and cosine iterations ride along.
	typedef struct packed {
		logic [63:0]        rem;
		logic [63:0]        res;
		logic signed [33:0] cx;
		logic signed [33:0] cy;
		logic signed [35:0] cz;
		logic               flip;
		logic [2:0][31:0]   mag;
		logic [2:0]         neg;
		logic [2:0][31:0]   pt;
	} root_t;

	// Divider stage record, three axis components in parallel.
	typedef struct packed {
		logic [2:0][63:0]   rem;
		logic [2:0][30:0]   quo;
		logic [31:0]        len;
		logic               zero;
		logic signed [31:0] s;
		logic signed [31:0] c;
		logic [2:0]         neg;
		logic [2:0][31:0]   pt;
	} div_t;

	// round(atan(2^-k) * 2^30)
	function automatic logic [29:0] atan_q30(input logic [4:0] k);
		logic [29:0] v;
		case (k)
			5'd0: v = 30'd843314857;
			5'd1: v = 30'd497837829;
			5'd2: v = 30'd263043837;
			5'd3: v = 30'd133525159;
			5'd4: v = 30'd67021687;
			5'd5: v = 30'd33543516;
			5'd6: v = 30'd16775851;
			5'd7: v = 30'd8388437;
			5'd8: v = 30'd4194283;
			5'd9: v = 30'd2097149;
			5'd10: v = 30'd1048576;
			5'd11: v = 30'd524288;
			5'd12: v = 30'd262144;
			5'd13: v = 30'd131072;
			5'd14: v = 30'd65536;
			5'd15: v = 30'd32768;
			5'd16: v = 30'd16384;
			5'd17: v = 30'd8192;
			5'd18: v = 30'd4096;
			5'd19: v = 30'd2048;
			5'd20: v = 30'd1024;
			5'd21: v = 30'd512;
			5'd22: v = 30'd256;
			5'd23: v = 30'd128;
			5'd24: v = 30'd64;
			5'd25: v = 30'd32;
			5'd26: v = 30'd16;
			5'd27: v = 30'd8;
			5'd28: v = 30'd4;
			5'd29: v = 30'd2;
			5'd30: v = 30'd1;
			default: v = 30'd0;
		endcase
		return v;
	endfunction

endpackage

FILE: src/axis_angle_point_rotation_core.sv
// ----------------------------------------------------------------------------
// Axis-angle point rotation core
// Rotates a Q15.16 point about an arbitrary axis by Rodrigues' formula in a
// fully pipelined datapath accepting one word per clock while not stalled.
// ----------------------------------------------------------------------------
//
//  Channel  | Handshake                   | Word
//  ---------+-----------------------------+----------------------------------
//  item     | item_valid / item_ready     | axis, angle (Q3.20), point
//  result   | result_valid / result_ready | rotated point, axis_error
//
// One word enters per clock while the result side is not stalled. Most of the
// pipeline depth is the 32-stage square root of the axis length followed by
// the 31-stage restoring dividers that normalise the axis; the sine and
// cosine iterations run alongside the square root stages.
// Reset clears only the valid bits of the pipeline; data registers hold junk.
// A stall on the result side freezes every stage at once, so nothing is lost
// or repeated, and item_ready is low exactly while the output word waits.
//
module axis_angle_point_rotation_core #(
	parameter int TRIG_ITERATIONS = 20
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                item_valid,
	output logic                item_ready,
	input  aapr_pkg::in_word_t  item,
	output logic                result_valid,
	input  logic                result_ready,
	output aapr_pkg::out_word_t result
);

	localparam int RS = aapr_pkg::ROOT_STEPS;
	localparam int DS = aapr_pkg::DIV_STEPS;

	// The whole pipeline advances together whenever the output stage is free
	// or its word is being taken.
	logic adv;
	assign adv        = !result_valid || result_ready;
	assign item_ready = adv;

	// One square root iteration (one result bit) plus, for the first
	// TRIG_ITERATIONS stages, one rotation-mode CORDIC iteration.
	function automatic aapr_pkg::root_t root_step(input aapr_pkg::root_t st, input int j);
		aapr_pkg::root_t    nx;
		logic [63:0]        bitv;
		logic [63:0]        trial;
		logic signed [33:0] dx;
		logic signed [33:0] dy;
		logic signed [35:0] at;
		nx    = st;
		bitv  = 64'd1 << (62 - 2 * j);
		trial = st.res + bitv;
		if (st.rem >= trial) begin
			nx.rem = st.rem - trial;
			nx.res = (st.res >> 1) + bitv;
		end else begin
			nx.res = st.res >> 1;
		end
		dx = st.cy >>> j;
		dy = st.cx >>> j;
		at = $signed({6'd0, aapr_pkg::atan_q30(5'(j))});
		if (j < TRIG_ITERATIONS) begin
			if (!st.cz[35]) begin
				nx.cx = st.cx - dx;
				nx.cy = st.cy + dy;
				nx.cz = st.cz - at;
			end else begin
				nx.cx = st.cx + dx;
				nx.cy = st.cy - dy;
				nx.cz = st.cz + at;
			end
		end
		return nx;
	endfunction

	// One quotient bit of each of the three normalising divisions.
	function automatic aapr_pkg::div_t div_step(input aapr_pkg::div_t st, input int d);
		aapr_pkg::div_t nx;
		logic [63:0]    dv;
		nx = st;
		dv = 64'(st.len) << (30 - d);
		for (int k = 0; k < 3; k++) begin
			if (st.rem[k] >= dv) begin
				nx.rem[k]          = st.rem[k] - dv;
				nx.quo[k][30 - d]  = 1'b1;
			end
		end
		return nx;
	endfunction

	function automatic logic signed [31:0] clamp_unit(input logic signed [34:0] v);
		logic signed [31:0] r;
		if (v > 35'sd1073741824) begin
			r = 32'sd1073741824;
		end else if (v < -35'sd1073741824) begin
			r = -32'sd1073741824;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

	// Q2.30 product rounded half up.
	function automatic logic signed [32:0] mul_q30(input logic signed [32:0] a,
		input logic signed [32:0] b);
		logic signed [65:0] p;
		p = a * b + aapr_pkg::HALF_Q30;
		return p[62:30];
	endfunction

	// ------------------------------------------------------------------
	// Stage 1: magnitudes of the axis and first step of angle reduction.
	// ------------------------------------------------------------------
	logic [2:0][31:0]   ax_in;
	logic [2:0][31:0]   pt_in;
	logic signed [35:0] z_in;
	logic signed [35:0] z_red;

	assign ax_in = {item.axis_z, item.axis_y, item.axis_x};
	assign pt_in = {item.point_z, item.point_y, item.point_x};
	assign z_in  = $signed({{2{item.angle[23]}}, item.angle, 10'd0});

	always_comb begin
		if (z_in > aapr_pkg::PI_Q30) begin
			z_red = z_in - aapr_pkg::TWO_PI_Q30;
		end else if (z_in < -aapr_pkg::PI_Q30) begin
			z_red = z_in + aapr_pkg::TWO_PI_Q30;
		end else begin
			z_red = z_in;
		end
	end

	logic               v_s1;
	logic [2:0][31:0]   mag_s1;
	logic [2:0]         neg_s1;
	logic [2:0][31:0]   pt_s1;
	logic signed [35:0] z_s1;

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int k = 0; k < 3; k++) begin
				mag_s1[k] <= ax_in[k][31] ? (~ax_in[k] + 32'd1) : ax_in[k];
				neg_s1[k] <= ax_in[k][31];
			end
			pt_s1 <= pt_in;
			z_s1  <= z_red;
		end
	end

	// ------------------------------------------------------------------
	// Stage 2: squares of the axis components; half-turn reduction of the
	// angle, which negates both sine and cosine.
	// ------------------------------------------------------------------
	logic               v_s2;
	logic [2:0][63:0]   sqr_s2;
	logic [2:0][31:0]   mag_s2;
	logic [2:0]         neg_s2;
	logic [2:0][31:0]   pt_s2;
	logic signed [35:0] z_s2;
	logic               flip_s2;

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int k = 0; k < 3; k++) begin
				sqr_s2[k] <= 64'(mag_s1[k]) * 64'(mag_s1[k]);
			end
			mag_s2 <= mag_s1;
			neg_s2 <= neg_s1;
			pt_s2  <= pt_s1;
			if (z_s1 > aapr_pkg::HALF_PI_Q30) begin
				z_s2    <= z_s1 - aapr_pkg::PI_Q30;
				flip_s2 <= 1'b1;
			end else if (z_s1 < -aapr_pkg::HALF_PI_Q30) begin
				z_s2    <= z_s1 + aapr_pkg::PI_Q30;
				flip_s2 <= 1'b1;
			end else begin
				z_s2    <= z_s1;
				flip_s2 <= 1'b0;
			end
		end
	end

	// ------------------------------------------------------------------
	// Stage 3 is the head of the square root pipeline: the summed squares
	// and the CORDIC start vector. Each further stage resolves one root bit.
	// ------------------------------------------------------------------
	aapr_pkg::root_t root_s [RS+1];
	logic [RS:0]     root_v_s;

	always_ff @(posedge clk) begin
		if (adv) begin
			root_s[0].rem  <= sqr_s2[0] + sqr_s2[1] + sqr_s2[2];
			root_s[0].res  <= 64'd0;
			root_s[0].cx   <= aapr_pkg::GAIN_Q30;
			root_s[0].cy   <= 34'sd0;
			root_s[0].cz   <= z_s2;
			root_s[0].flip <= flip_s2;
			root_s[0].mag  <= mag_s2;
			root_s[0].neg  <= neg_s2;
			root_s[0].pt   <= pt_s2;
			for (int j = 0; j < RS; j++) begin
				root_s[j+1] <= root_step(root_s[j], j);
			end
		end
	end

	// ------------------------------------------------------------------
	// Divider head: length, rounded numerators, and the final sine and
	// cosine with the half-turn sign applied and clamped to the unit range.
	// ------------------------------------------------------------------
	aapr_pkg::root_t    rt_end;
	logic [31:0]        len_w;
	logic signed [33:0] fx;
	logic signed [33:0] fy;

	assign rt_end = root_s[RS];
	assign len_w  = rt_end.res[31:0];
	assign fx     = rt_end.flip ? -rt_end.cx : rt_end.cx;
	assign fy     = rt_end.flip ? -rt_end.cy : rt_end.cy;

	aapr_pkg::div_t div_s [DS+1];
	logic [DS:0]    div_v_s;

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int k = 0; k < 3; k++) begin
				div_s[0].rem[k] <= (64'(rt_end.mag[k]) << 30) + 64'(len_w >> 1);
			end
			div_s[0].quo  <= '0;
			div_s[0].len  <= len_w;
			div_s[0].zero <= (len_w == 32'd0);
			div_s[0].s    <= clamp_unit(35'(fy));
			div_s[0].c    <= clamp_unit(35'(fx));
			div_s[0].neg  <= rt_end.neg;
			div_s[0].pt   <= rt_end.pt;
			for (int d = 0; d < DS; d++) begin
				div_s[d+1] <= div_step(div_s[d], d);
			end
		end
	end

	// ------------------------------------------------------------------
	// Stage 4: signed unit axis and one minus cosine.
	// ------------------------------------------------------------------
	aapr_pkg::div_t     dv_end;
	logic               v_s4;
	logic signed [32:0] u_s4 [3];
	logic signed [31:0] s_s4;
	logic signed [31:0] c_s4;
	logic signed [32:0] omc_s4;
	logic               zero_s4;
	logic [2:0][31:0]   pt_s4;

	assign dv_end = div_s[DS];

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int k = 0; k < 3; k++) begin
				if (dv_end.quo[k] > 31'd1073741824) begin
					u_s4[k] <= dv_end.neg[k] ? -33'sd1073741824 : 33'sd1073741824;
				end else begin
					u_s4[k] <= dv_end.neg[k] ? -$signed({2'b00, dv_end.quo[k]})
						: $signed({2'b00, dv_end.quo[k]});
				end
			end
			s_s4    <= dv_end.s;
			c_s4    <= dv_end.c;
			omc_s4  <= aapr_pkg::ONE_Q30 - 33'(dv_end.c);
			zero_s4 <= dv_end.zero;
			pt_s4   <= dv_end.pt;
		end
	end

	// ------------------------------------------------------------------
	// Stage 5: the six distinct products u_i*u_j and the three u_k*s.
	// Order of uu: xx, xy, xz, yy, yz, zz.
	// ------------------------------------------------------------------
	logic               v_s5;
	logic signed [32:0] uu_s5 [6];
	logic signed [32:0] us_s5 [3];
	logic signed [31:0] c_s5;
	logic signed [32:0] omc_s5;
	logic               zero_s5;
	logic [2:0][31:0]   pt_s5;

	always_ff @(posedge clk) begin
		if (adv) begin
			uu_s5[0] <= mul_q30(u_s4[0], u_s4[0]);
			uu_s5[1] <= mul_q30(u_s4[0], u_s4[1]);
			uu_s5[2] <= mul_q30(u_s4[0], u_s4[2]);
			uu_s5[3] <= mul_q30(u_s4[1], u_s4[1]);
			uu_s5[4] <= mul_q30(u_s4[1], u_s4[2]);
			uu_s5[5] <= mul_q30(u_s4[2], u_s4[2]);
			for (int k = 0; k < 3; k++) begin
				us_s5[k] <= mul_q30(u_s4[k], 33'(s_s4));
			end
			c_s5    <= c_s4;
			omc_s5  <= omc_s4;
			zero_s5 <= zero_s4;
			pt_s5   <= pt_s4;
		end
	end

	// ------------------------------------------------------------------
	// Stage 6: scale the outer product by one minus cosine.
	// ------------------------------------------------------------------
	logic               v_s6;
	logic signed [32:0] uuo_s6 [6];
	logic signed [32:0] us_s6 [3];
	logic signed [31:0] c_s6;
	logic               zero_s6;
	logic [2:0][31:0]   pt_s6;

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int k = 0; k < 6; k++) begin
				uuo_s6[k] <= mul_q30(uu_s5[k], omc_s5);
			end
			us_s6   <= us_s5;
			c_s6    <= c_s5;
			zero_s6 <= zero_s5;
			pt_s6   <= pt_s5;
		end
	end

	// ------------------------------------------------------------------
	// Stage 7: assemble the nine matrix entries, each clamped to the range
	// of a rotation matrix.
	// ------------------------------------------------------------------
	logic signed [34:0] cc;
	logic signed [34:0] mraw [9];

	assign cc = 35'(c_s6);

	always_comb begin
		mraw[0] = cc + 35'(uuo_s6[0]);
		mraw[1] = 35'(uuo_s6[1]) - 35'(us_s6[2]);
		mraw[2] = 35'(uuo_s6[2]) + 35'(us_s6[1]);
		mraw[3] = 35'(uuo_s6[1]) + 35'(us_s6[2]);
		mraw[4] = cc + 35'(uuo_s6[3]);
		mraw[5] = 35'(uuo_s6[4]) - 35'(us_s6[0]);
		mraw[6] = 35'(uuo_s6[2]) - 35'(us_s6[1]);
		mraw[7] = 35'(uuo_s6[4]) + 35'(us_s6[0]);
		mraw[8] = cc + 35'(uuo_s6[5]);
	end

	logic               v_s7;
	logic signed [31:0] m_s7 [9];
	logic               zero_s7;
	logic [2:0][31:0]   pt_s7;

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int k = 0; k < 9; k++) begin
				m_s7[k] <= clamp_unit(mraw[k]);
			end
			zero_s7 <= zero_s6;
			pt_s7   <= pt_s6;
		end
	end

	// ------------------------------------------------------------------
	// Stage 8: entry-by-coordinate products.
	// ------------------------------------------------------------------
	logic               v_s8;
	logic signed [63:0] prod_s8 [9];
	logic               zero_s8;
	logic [2:0][31:0]   pt_s8;

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int r = 0; r < 3; r++) begin
				for (int k = 0; k < 3; k++) begin
					prod_s8[r*3 + k] <= m_s7[r*3 + k] * $signed(pt_s7[k]);
				end
			end
			zero_s8 <= zero_s7;
			pt_s8   <= pt_s7;
		end
	end

	// ------------------------------------------------------------------
	// Stage 9 (output): row sums, rounding, saturation and the bypass for a
	// zero-length axis.
	// ------------------------------------------------------------------
	logic signed [65:0] acc [3];
	logic signed [35:0] shr [3];
	logic [2:0][31:0]   rot;

	always_comb begin
		for (int r = 0; r < 3; r++) begin
			acc[r] = 66'(prod_s8[r*3]) + 66'(prod_s8[r*3 + 1]) + 66'(prod_s8[r*3 + 2])
				+ aapr_pkg::HALF_Q30;
			shr[r] = acc[r][65:30];
			if (zero_s8) begin
				rot[r] = pt_s8[r];
			end else if (shr[r] > 36'sd2147483647) begin
				rot[r] = 32'h7fff_ffff;
			end else if (shr[r] < -36'sd2147483648) begin
				rot[r] = 32'h8000_0000;
			end else begin
				rot[r] = shr[r][31:0];
			end
		end
	end

	aapr_pkg::out_word_t out_s9;
	logic                v_s9;

	always_ff @(posedge clk) begin
		if (adv) begin
			out_s9.rotated_x  <= rot[0];
			out_s9.rotated_y  <= rot[1];
			out_s9.rotated_z  <= rot[2];
			out_s9.axis_error <= zero_s8;
		end
	end

	// Valid bits travel with the words.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1     <= 1'b0;
			v_s2     <= 1'b0;
			root_v_s <= '0;
			div_v_s  <= '0;
			v_s4     <= 1'b0;
			v_s5     <= 1'b0;
			v_s6     <= 1'b0;
			v_s7     <= 1'b0;
			v_s8     <= 1'b0;
			v_s9     <= 1'b0;
		end else if (adv) begin
			v_s1     <= item_valid;
			v_s2     <= v_s1;
			root_v_s <= {root_v_s[RS-1:0], v_s2};
			div_v_s  <= {div_v_s[DS-1:0], root_v_s[RS]};
			v_s4     <= div_v_s[DS];
			v_s5     <= v_s4;
			v_s6     <= v_s5;
			v_s7     <= v_s6;
			v_s8     <= v_s7;
			v_s9     <= v_s8;
		end
	end

	assign result_valid = v_s9;
	assign result       = out_s9;

endmodule

FILE: src/aapr_checker.sv
// ----------------------------------------------------------------------------
// Axis-angle point rotation checker
// Port-level assertions on the flow control of the rotation core.
// ----------------------------------------------------------------------------
module aapr_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                item_valid,
	input logic                item_ready,
	input aapr_pkg::in_word_t  item,
	input logic                result_valid,
	input logic                result_ready,
	input aapr_pkg::out_word_t result
);

	// A blocked output word must stall the input side.
	a_stall_back: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |-> !item_ready)
		else $error("input accepted while the output word is stalled");

	// With nothing waiting at the output the core always takes a word.
	a_free_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!result_valid |-> item_ready)
		else $error("input refused with an empty output stage");

	// A word offered at the output stays until taken.
	a_valid_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid)
		else $error("output word withdrawn before it was taken");

	a_data_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> $stable(result))
		else $error("output word changed while stalled");

	// A refused input word stays on offer unchanged.
	a_item_hold: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && !item_ready |=> item_valid && $stable(item))
		else $error("input word withdrawn or changed before it was taken");

endmodule

bind axis_angle_point_rotation_core aapr_checker u_aapr_checker (.*);
